>>> design/assert_macros.svh
// Assertion macros shared by the design files.
// Real checks in simulation; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define SRP_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
// Condition a implies condition b in the next cycle.
`define SRP_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
// Condition a holds in every cycle out of reset.
`define SRP_ASSERT_ALWAYS(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
        else $error("invariant check failed");
`else
`define SRP_ASSERT_IMPL(label, clk, rst_n, a, b)
`define SRP_ASSERT_NEXT(label, clk, rst_n, a, b)
`define SRP_ASSERT_ALWAYS(label, clk, rst_n, a)
`endif
`endif

>>> design/srp_pkg.sv
// Shared types and constants for the sliding-window range peak block.
// No dependencies.
package srp_pkg;

    localparam int DATA_W = 31;
    localparam int CFG_W  = 7;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd4;

    // Per-item control carried down the pipeline.
    typedef struct packed {
        logic ready;
        logic last;
    } srp_ctrl_t;

endpackage

>>> design/srp_cell.sv
// One window cell: running max and min over the newest entries up to its position.
// Depends on srp_pkg.
module srp_cell (
    input  logic                       clk,
    input  logic                       en,
    input  logic                       fresh,
    input  logic [srp_pkg::DATA_W-1:0] sample,
    input  logic [srp_pkg::DATA_W-1:0] prev_max,
    input  logic [srp_pkg::DATA_W-1:0] prev_min,
    output logic [srp_pkg::DATA_W-1:0] max_out,
    output logic [srp_pkg::DATA_W-1:0] min_out
);
    import srp_pkg::*;

    logic [DATA_W-1:0] max_reg, max_next;
    logic [DATA_W-1:0] min_reg, min_next;

    // After a shift, cell i covers the new sample plus what cell i-1 covered.
    always_comb
    begin
        if (fresh)
        begin
            max_next = sample;
            min_next = sample;
        end
        else
        begin
            max_next = (sample > prev_max) ? sample : prev_max;
            min_next = (sample < prev_min) ? sample : prev_min;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            max_reg <= max_next;
            min_reg <= min_next;
        end
    end

    assign max_out = max_reg;
    assign min_out = min_reg;

endmodule

>>> design/srp_select.sv
// Registered pick of the cell max/min at the window's last position.
// Depends on srp_pkg.
module srp_select #(
    parameter int WINDOW_MAX = 64,
    parameter int IW         = 6
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [IW-1:0]              idx,
    input  logic [srp_pkg::DATA_W-1:0] cell_max [WINDOW_MAX],
    input  logic [srp_pkg::DATA_W-1:0] cell_min [WINDOW_MAX],
    output logic [srp_pkg::DATA_W-1:0] win_max,
    output logic [srp_pkg::DATA_W-1:0] win_min
);
    import srp_pkg::*;

    logic [DATA_W-1:0] max_reg;
    logic [DATA_W-1:0] min_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            max_reg <= cell_max[idx];
            min_reg <= cell_min[idx];
        end
    end

    assign win_max = max_reg;
    assign win_min = min_reg;

endmodule

>>> design/sliding_window_range_peak.sv
// Top level of the sliding-window range peak block.
// Depends on srp_pkg, srp_cell, srp_select and assert_macros.svh.
//
// Usage:
//   Input stream s_*: one sample per item, tdata[30:0] = sample_value,
//   tlast = last_item (final sample of a sequence).
//   Output stream m_*: one result per sample. tuser = window_ready,
//   tdata[30:0] = window_spread, tdata[61:31] = best_spread, tdata[63:62] = 0,
//   tlast = sequence_done.
//   cfg_we/cfg_wdata write window_size (0 acts as 1, values above WINDOW_MAX
//   act as WINDOW_MAX); write only while no item is in flight.
// Timing:
//   One item per cycle sustained while m_tready takes each result. Steps for a
//   sample: cell chain update at the edge that accepts it, registered pick at
//   the window end, then spread/best compare into the output register.
// Reset:
//   window_size returns to 4, sample count and best spread clear; the cell
//   chain starts a fresh sequence. After a tlast item the same happens
//   without touching window_size.
// Back-pressure:
//   When the output holds a result that is not taken, the whole pipeline
//   freezes and s_tready drops; nothing is lost or repeated.
`include "assert_macros.svh"

module sliding_window_range_peak #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // config
    input  logic                      cfg_we,
    input  logic [srp_pkg::CFG_W-1:0] cfg_wdata,   // window_size
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,     // [30:0] sample_value, [31] zero
    input  logic                      s_tlast,     // last_item
    // output stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [63:0]               m_tdata,     // [30:0] window_spread,
                                                   // [61:31] best_spread, [63:62] zero
    output logic                      m_tuser,     // window_ready
    output logic                      m_tlast      // sequence_done
);
    import srp_pkg::*;

    // Count width holds WINDOW_MAX itself; index width addresses the cells.
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;

    // ---------------- config register ----------------
    logic [CFG_W-1:0] window_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_size_reg <= WINDOW_SIZE_RESET;
        else if (cfg_we)
            window_size_reg <= cfg_wdata;
    end

    // Clamp the window size into 1..WINDOW_MAX.
    logic [EW-1:0] cfg_ext;
    logic [CW-1:0] w_eff;

    always_comb
    begin
        cfg_ext = EW'(window_size_reg);
        if (cfg_ext == '0)
            w_eff = CW'(1);
        else if (cfg_ext > EW'(WINDOW_MAX))
            w_eff = CW'(WINDOW_MAX);
        else
            w_eff = CW'(cfg_ext);
    end

    // ---------------- handshake / pipeline enable ----------------
    logic m_tvalid_reg;
    logic pipe_en;
    logic in_accept;

    // Whole pipeline moves unless a result sits unclaimed at the output.
    assign pipe_en   = !m_tvalid_reg || m_tready;
    assign s_tready  = pipe_en;
    assign in_accept = s_tvalid && s_tready;

    // ---------------- stage 1: sequence tracking + cell chain ----------------
    logic [DATA_W-1:0] sample;
    logic              fresh_reg;    // next item starts a new sequence
    logic [CW-1:0]     seen_reg, seen_next;
    logic              v1_reg;
    srp_ctrl_t         ctrl1_reg, ctrl1_next;
    logic [IW-1:0]     idx1_reg;

    assign sample = s_tdata[DATA_W-1:0];

    always_comb
    begin
        if (fresh_reg)
            seen_next = CW'(1);
        else if (seen_reg == CW'(WINDOW_MAX))
            seen_next = seen_reg;
        else
            seen_next = seen_reg + CW'(1);
        ctrl1_next.ready = (seen_next >= w_eff);
        ctrl1_next.last  = s_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= 1'b1;
            seen_reg  <= '0;
            v1_reg    <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg <= in_accept;
            if (in_accept)
            begin
                fresh_reg <= s_tlast;
                seen_reg  <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ctrl1_reg <= ctrl1_next;
            idx1_reg  <= IW'(w_eff - CW'(1));
        end
    end

    // Cell i holds max/min of the newest i+1 samples of the sequence.
    logic [DATA_W-1:0] cell_max [WINDOW_MAX];
    logic [DATA_W-1:0] cell_min [WINDOW_MAX];

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            logic [DATA_W-1:0] prev_max;
            logic [DATA_W-1:0] prev_min;
            if (gi == 0)
            begin : g_head
                assign prev_max = sample;
                assign prev_min = sample;
            end
            else
            begin : g_body
                assign prev_max = cell_max[gi-1];
                assign prev_min = cell_min[gi-1];
            end

            srp_cell u_cell (
                .clk      (clk),
                .en       (in_accept),
                .fresh    (fresh_reg),
                .sample   (sample),
                .prev_max (prev_max),
                .prev_min (prev_min),
                .max_out  (cell_max[gi]),
                .min_out  (cell_min[gi])
            );
        end
    endgenerate

    // ---------------- stage 2: pick window end ----------------
    logic              v2_reg;
    srp_ctrl_t         ctrl2_reg;
    logic [DATA_W-1:0] win_max;
    logic [DATA_W-1:0] win_min;

    srp_select #(
        .WINDOW_MAX (WINDOW_MAX),
        .IW         (IW)
    ) u_select (
        .clk      (clk),
        .en       (pipe_en && v1_reg),
        .idx      (idx1_reg),
        .cell_max (cell_max),
        .cell_min (cell_min),
        .win_max  (win_max),
        .win_min  (win_min)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (pipe_en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && v1_reg)
            ctrl2_reg <= ctrl1_reg;
    end

    // ---------------- stage 3: spread, best, output register ----------------
    logic [DATA_W-1:0] spread;
    logic [DATA_W-1:0] best_reg, best_next;
    logic [DATA_W-1:0] best_out;
    logic [DATA_W-1:0] spread_out_reg;
    logic [DATA_W-1:0] best_out_reg;
    logic              ready_out_reg;
    logic              last_out_reg;

    always_comb
    begin
        spread   = ctrl2_reg.ready ? (win_max - win_min) : '0;
        best_out = (spread > best_reg) ? spread : best_reg;
        // Best spread restarts after the final item of a sequence.
        best_next = ctrl2_reg.last ? '0 : best_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            m_tvalid_reg <= v2_reg;
            if (v2_reg)
                best_reg <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && v2_reg)
        begin
            spread_out_reg <= spread;
            best_out_reg   <= best_out;
            ready_out_reg  <= ctrl2_reg.ready;
            last_out_reg   <= ctrl2_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, best_out_reg, spread_out_reg};
    assign m_tuser  = ready_out_reg;
    assign m_tlast  = last_out_reg;

    // ---------------- checks ----------------
    // No spread before a full window.
    `SRP_ASSERT_IMPL(a_spread_zero_not_ready, clk, rst_n, m_tvalid && !m_tuser, m_tdata[30:0] == '0)
    // Best spread never trails the current spread.
    `SRP_ASSERT_IMPL(a_best_ge_spread, clk, rst_n, m_tvalid, m_tdata[61:31] >= m_tdata[30:0])
    // A last item starts a new sequence for the next sample.
    `SRP_ASSERT_NEXT(a_last_restarts, clk, rst_n, in_accept && s_tlast, fresh_reg)
    // Sample count saturates at the window capacity.
    `SRP_ASSERT_ALWAYS(a_seen_bounded, clk, rst_n, seen_reg <= CW'(WINDOW_MAX))

endmodule

>>> sim/tb_sliding_window_range_peak.sv
// Self-checking testbench for sliding_window_range_peak: a directed table, then random
// sequences at several window sizes, with random gaps and stalls on both streams.
// Depends on srp_pkg and the RTL of the block; reads and writes no files.
module tb_sliding_window_range_peak;
    timeunit 1ns;
    timeprecision 1ps;

    import srp_pkg::*;

    localparam int SPAN_MAX     = 64;     // depth of the window store in the block
    localparam int RANDOM_ITEMS = 1700;   // random samples to send after the table
    localparam int DRAIN_CYCLES = 8;      // extra wait after the queue empties, with margin
    localparam int IDLE_LIMIT   = 2000;   // cycles with no handshake before giving up
    localparam int REPORT_MAX   = 10;

    localparam logic [DATA_W-1:0] TOP_VAL = '1;

    // One result item as seen on the output stream.
    typedef struct packed {
        logic              ready;    // m_tuser
        logic [DATA_W-1:0] spread;   // m_tdata[30:0]
        logic [DATA_W-1:0] best;     // m_tdata[61:31]
        logic              done;     // m_tlast
    } range_res_t;

    // One row of the directed table. set_cfg writes cfg_val before the item;
    // typed rows carry a hand-written result, the rest use the predictor.
    typedef struct packed {
        logic              set_cfg;
        logic [CFG_W-1:0]  cfg_val;
        logic [DATA_W-1:0] val;
        logic              closes;
        logic              typed;
        range_res_t        res;
    } stim_row_t;

    typedef enum logic [1:0] {
        FILL_FULL,     // any 31-bit value
        FILL_NARROW,   // 0..15, lots of ties
        FILL_EDGES     // 0, 1, max-1, max
    } fill_mode_t;

    localparam range_res_t R_COLD     = '{1'b0, '0, '0, 1'b0};
    localparam range_res_t R_COLD_END = '{1'b0, '0, '0, 1'b1};
    localparam range_res_t R_FULL     = '{1'b1, TOP_VAL, TOP_VAL, 1'b0};
    localparam range_res_t R_FULL_END = '{1'b1, TOP_VAL, TOP_VAL, 1'b1};
    localparam range_res_t R_FLAT     = '{1'b1, '0, '0, 1'b0};
    localparam range_res_t R_FLAT_END = '{1'b1, '0, '0, 1'b1};
    localparam range_res_t R_CALC     = '0;

    // Starts at the reset window size of 4.
    localparam stim_row_t DIRECTED [24] = '{
        // filling a window of 4: nothing ready yet
        '{1'b0, 7'd0,   31'd5,          1'b0, 1'b1, R_COLD},
        '{1'b0, 7'd0,   TOP_VAL,        1'b0, 1'b1, R_COLD},
        '{1'b0, 7'd0,   31'd0,          1'b0, 1'b1, R_COLD},
        // first full window holds 0 and max: widest possible spread
        '{1'b0, 7'd0,   31'd7,          1'b0, 1'b1, R_FULL},
        '{1'b0, 7'd0,   31'd3,          1'b1, 1'b1, R_FULL_END},
        // sequence of one, shorter than the window
        '{1'b0, 7'd0,   31'd9,          1'b1, 1'b1, R_COLD_END},
        // size zero acts as one: ready at once, spread always zero
        '{1'b1, 7'd0,   31'd100,        1'b0, 1'b1, R_FLAT},
        '{1'b0, 7'd0,   TOP_VAL,        1'b1, 1'b1, R_FLAT_END},
        // size above the store depth acts as the depth
        '{1'b1, 7'd127, 31'd1,          1'b0, 1'b1, R_COLD},
        '{1'b0, 7'd0,   TOP_VAL,        1'b0, 1'b1, R_COLD},
        // shrink mid-sequence, then change again before the end
        '{1'b1, 7'd2,   31'd10,         1'b0, 1'b0, R_CALC},
        '{1'b0, 7'd0,   31'd4,          1'b0, 1'b0, R_CALC},
        '{1'b1, 7'd1,   31'd20,         1'b0, 1'b0, R_CALC},
        '{1'b1, 7'd3,   31'h2AAAAAAA,   1'b0, 1'b0, R_CALC},
        '{1'b0, 7'd0,   31'h55555555,   1'b1, 1'b0, R_CALC},
        // largest window, short sequence of equal values
        '{1'b1, 7'd64,  31'd6,          1'b0, 1'b0, R_CALC},
        '{1'b0, 7'd0,   31'd6,          1'b0, 1'b0, R_CALC},
        '{1'b0, 7'd0,   31'd6,          1'b1, 1'b0, R_CALC},
        '{1'b1, 7'd65,  31'd0,          1'b1, 1'b0, R_CALC},
        // back to 4, rising ramp then a max
        '{1'b1, 7'd4,   31'd1,          1'b0, 1'b0, R_CALC},
        '{1'b0, 7'd0,   31'd2,          1'b0, 1'b0, R_CALC},
        '{1'b0, 7'd0,   31'd3,          1'b0, 1'b0, R_CALC},
        '{1'b0, 7'd0,   31'd4,          1'b0, 1'b0, R_CALC},
        '{1'b0, 7'd0,   TOP_VAL,        1'b1, 1'b0, R_CALC}
    };

    // DUT ports; every input has a known value from time zero.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [63:0]           m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // Shadow of the block state used for prediction.
    logic [DATA_W-1:0]     shadow_win [SPAN_MAX];   // newest sample at index 0
    int unsigned           shadow_seen;             // saturates at SPAN_MAX
    logic [DATA_W-1:0]     shadow_best;
    logic [CFG_W-1:0]      shadow_cfg;

    range_res_t            pending_ranges [$];      // oldest expected result first
    int                    mismatches  = 0;
    int                    quiet_cycles = 0;
    int                    stall_left  = 0;
    logic                  rx_calm     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sliding_window_range_peak #(
        .WINDOW_MAX (SPAN_MAX)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Register value to the number of samples actually compared.
    function automatic int eff_span(input logic [CFG_W-1:0] size);
        if (size == '0)
            return 1;
        if (int'(size) > SPAN_MAX)
            return SPAN_MAX;
        return int'(size);
    endfunction

    function automatic void clear_run();
        for (int i = 0; i < SPAN_MAX; i++)
            shadow_win[i] = '0;
        shadow_seen = 0;
        shadow_best = '0;
    endfunction

    // Shift the sample in, form the result, clear the run after a last item.
    function automatic range_res_t advance_window(input logic [DATA_W-1:0] val,
                                                  input logic closes);
        int                span;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        range_res_t        res;
        span = eff_span(shadow_cfg);
        for (int i = SPAN_MAX - 1; i > 0; i--)
            shadow_win[i] = shadow_win[i-1];
        shadow_win[0] = val;
        if (shadow_seen < SPAN_MAX)
            shadow_seen++;
        res = '0;
        res.ready = (shadow_seen >= span);
        if (res.ready)
        begin
            hi = shadow_win[0];
            lo = shadow_win[0];
            for (int i = 1; i < span; i++)
            begin
                if (shadow_win[i] > hi)
                    hi = shadow_win[i];
                if (shadow_win[i] < lo)
                    lo = shadow_win[i];
            end
            res.spread = hi - lo;
            if (res.spread > shadow_best)
                shadow_best = res.spread;
        end
        res.best = shadow_best;
        res.done = closes;
        if (closes)
            clear_run();
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic int tx_gap();
        if ($urandom_range(0, 1) == 0)
            return 0;
        return pick_gap();
    endfunction

    function automatic logic [DATA_W-1:0] draw_val(input fill_mode_t fill);
        logic [31:0] raw;
        case (fill)
            FILL_NARROW: raw = $urandom_range(0, 15);
            FILL_EDGES:
            begin
                case ($urandom_range(0, 3))
                    0:       raw = '0;
                    1:       raw = 32'd1;
                    2:       raw = {1'b0, TOP_VAL - 31'd1};
                    default: raw = {1'b0, TOP_VAL};
                endcase
            end
            default:     raw = $urandom();
        endcase
        return raw[DATA_W-1:0];
    endfunction

    // Present one sample and hold it until taken. tvalid stays high afterwards
    // so back-to-back items need no second assignment in the same step.
    task automatic offer(input logic [DATA_W-1:0] val, input logic closes,
                         input logic typed, input range_res_t typed_res);
        range_res_t res;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val};
        s_tlast  <= closes;
        do
            @(posedge clk);
        while (!s_tready);
        res = advance_window(val, closes);
        pending_ranges.insert(pending_ranges.size(), typed ? typed_res : res);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Window size may only change with nothing in flight.
    task automatic write_window(input logic [CFG_W-1:0] size);
        s_tvalid <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we     <= 1'b0;
        shadow_cfg = size;
    endtask

    // Output side: random stalls, with calm stretches where m_tready stays high.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            rx_calm <= !rx_calm;
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!rx_calm && $urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap() - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        range_res_t got;
        range_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[DATA_W-1:0], m_tdata[2*DATA_W-1:DATA_W], m_tlast};
            if (pending_ranges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%t: result with none expected: ready=%0d spread=%h best=%h done=%0d",
                             $realtime, got.ready, got.spread, got.best, got.done);
            end
            else
            begin
                want = pending_ranges.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"%t: mismatch exp ready=%0d spread=%h best=%h done=%0d",
                                  " got ready=%0d spread=%h best=%h done=%0d"},
                                 $realtime, want.ready, want.spread, want.best, want.done,
                                 got.ready, got.spread, got.best, got.done);
                end
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles < IDLE_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
        else
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int               sent;
        int               span;
        int               seqs;
        int               len;
        logic             open_end;
        logic             calm_tx;
        logic [CFG_W-1:0] size;
        fill_mode_t       fill;

        clear_run();
        shadow_cfg = WINDOW_SIZE_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int r = 0; r < $size(DIRECTED); r++)
        begin
            if (DIRECTED[r].set_cfg)
                write_window(DIRECTED[r].cfg_val);
            offer(DIRECTED[r].val, DIRECTED[r].closes, DIRECTED[r].typed, DIRECTED[r].res);
            hold_off(tx_gap());
        end

        // Random phases: pick a window size, then a few sequences. Most are
        // long enough to fill the window; the last one of a phase is sometimes
        // left open so the next size change lands mid-sequence.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       size = '0;
                1:       size = 7'd1;
                2:       size = 7'd64;
                3:       size = '1;
                4:       size = 7'd65;
                5, 6:    size = CFG_W'($urandom_range(2, 8));
                7:       size = CFG_W'($urandom_range(9, 63));
                default: size = CFG_W'($urandom_range(0, 127));
            endcase
            write_window(size);
            span = eff_span(size);
            seqs = $urandom_range(1, 4);
            for (int q = 0; q < seqs; q++)
            begin
                case ($urandom_range(0, 4))
                    0:       len = $urandom_range(1, span);
                    1:       len = $urandom_range(1, 3);
                    default: len = span + $urandom_range(0, 2 * span + 8);
                endcase
                open_end = (q == seqs - 1) && ($urandom_range(0, 2) == 0);
                fill     = fill_mode_t'($urandom_range(0, 2));
                calm_tx  = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < len && sent < RANDOM_ITEMS; k++)
                begin
                    offer(draw_val(fill), (k == len - 1) && !open_end, 1'b0, R_CALC);
                    sent++;
                    hold_off(calm_tx ? 0 : tx_gap());
                end
            end
        end

        // Drain and finish.
        s_tvalid <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/srp_pkg.sv
design/srp_cell.sv
design/srp_select.sv
design/sliding_window_range_peak.sv
sim/tb_sliding_window_range_peak.sv
